/* sv/rida_pkg.sv */
package rida_pkg;

	// Width of an id and of the configured base.
	localparam int IdW = 29;
	// Default size of the managed id range.
	localparam int ID_COUNT_DEF = 1024;
	// Bits of allocation state held in one word of the bitmap memory.
	localparam int WordW = 32;
	// Stream widths; the data widths are rounded up to whole bytes.
	localparam int InDataW = 32;
	localparam int OutDataW = 32;
	localparam int InUserW = 2;
	// Configuration port.
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;
	localparam logic [ApbAddrW-1:0] REG_ID_BASE = 3'd0;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RESERVE = 2'd1,
		REQ_FREE    = 2'd2,
		REQ_QUERY   = 2'd3
	} req_type_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_en;   // write one zero word of the clearing pass
		logic latch;    // capture the incoming request
		logic rd_en;    // read the bitmap word for the current request
		logic eval_go;  // commit the outcome of the word just read
	} rida_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last; // clearing pass is at its last word
		logic finish;   // the word just read settles the request
		logic out_free; // the output register can take a result this cycle
	} rida_stat_t;

endpackage

/* sv/rida_ctrl.sv */
module rida_ctrl import rida_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  rida_stat_t st,
	output rida_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			ST_READ: cmd.rd_en = 1'b1;
			ST_EVAL: cmd.eval_go = !st.finish || st.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: if (st.clr_last) state_q <= ST_IDLE;
				ST_IDLE: if (req_valid) state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					// An allocate that misses in this word goes back for the next one.
					if (!st.finish) state_q <= ST_READ;
					else if (st.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

/* sv/rida_dp.sv */
module rida_dp import rida_pkg::*; #(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rida_cmd_t           cmd,
	output rida_stat_t          st,
	input  logic [IdW-1:0]      id_base,
	input  logic [InUserW-1:0]  in_type,
	input  logic [IdW-1:0]      in_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OutDataW-1:0] out_data
);

	localparam int WORD_COUNT = (ID_COUNT + WordW - 1) / WordW;
	localparam int WAW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int CURW = ($clog2(ID_COUNT + 1) > 6) ? $clog2(ID_COUNT + 1) : 6;
	localparam int CW1 = CURW + 1;
	localparam int CWW = CURW - 5;
	localparam int LAST_WORD = (ID_COUNT - 1) / WordW;
	localparam int TAIL = ID_COUNT % WordW;
	localparam logic [WordW-1:0] LAST_MASK =
		(TAIL == 0) ? {WordW{1'b1}} : ((WordW'(1) << TAIL) - WordW'(1));

	logic [WordW-1:0] mem [WORD_COUNT];
	logic [WordW-1:0] rdata_q;
	logic [WAW-1:0]   clr_cnt_q;
	logic [CURW-1:0]  cursor_q;
	req_type_t        type_q;
	logic [IdW-1:0]   id_q;
	logic             out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	logic [IdW-1:0]   off;
	logic             inr;
	logic [WAW-1:0]   off_word;
	logic [4:0]       off_bit;
	logic [CWW-1:0]   cur_word;
	logic [4:0]       cur_bit;
	logic [WordW-1:0] lim_mask;
	logic [WordW-1:0] free_bits;
	logic [4:0]       idx;
	logic             hit;
	logic             exhausted;
	logic [CW1-1:0]   word_end;
	logic [WAW-1:0]   addr;
	logic             fin;
	logic             wr_cond;
	logic [WordW-1:0] wdata;
	logic             cur_upd;
	logic [CURW-1:0]  cur_nxt;
	logic [IdW-1:0]   r_id;
	logic             r_gr;
	logic             r_inr;

	always_comb begin
		off = id_q - id_base;
		inr = (id_q >= id_base) && (off < IdW'(ID_COUNT));
		off_word = WAW'(off[IdW-1:5]);
		off_bit = off[4:0];
		cur_word = cursor_q[CURW-1:5];
		cur_bit = cursor_q[4:0];
		lim_mask = (cur_word == CWW'(LAST_WORD)) ? LAST_MASK : {WordW{1'b1}};
		free_bits = ~rdata_q & ({WordW{1'b1}} << cur_bit) & lim_mask;
		idx = 5'd0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (free_bits[i]) idx = 5'(i);
		end
		hit = |free_bits;
		exhausted = (cursor_q == CURW'(ID_COUNT));
		word_end = ({1'b0, cursor_q} | CW1'(WordW - 1)) + CW1'(1);
		if (cmd.clr_en) addr = clr_cnt_q;
		else if (type_q == REQ_ALLOC) addr = WAW'(cur_word);
		else addr = off_word;
	end

	// Outcome of the word held in the read register.
	always_comb begin
		fin = 1'b1;
		wr_cond = 1'b0;
		wdata = rdata_q;
		cur_upd = 1'b0;
		cur_nxt = cursor_q;
		r_id = id_q;
		r_gr = 1'b0;
		r_inr = inr;
		case (type_q)
			REQ_ALLOC: begin
				r_id = '0;
				r_inr = 1'b0;
				if (!exhausted) begin
					cur_upd = 1'b1;
					if (hit) begin
						wr_cond = 1'b1;
						wdata = rdata_q | (WordW'(1) << idx);
						cur_nxt = {cur_word, idx} + CURW'(1);
						r_id = id_base + IdW'({cur_word, idx});
						r_gr = 1'b1;
						r_inr = 1'b1;
					end else if (word_end >= CW1'(ID_COUNT)) begin
						cur_nxt = CURW'(ID_COUNT);
					end else begin
						cur_nxt = word_end[CURW-1:0];
						fin = 1'b0;
					end
				end
			end
			REQ_RESERVE: begin
				if (inr && !rdata_q[off_bit]) begin
					wr_cond = 1'b1;
					wdata = rdata_q | (WordW'(1) << off_bit);
					r_gr = 1'b1;
				end
			end
			REQ_FREE: begin
				if (inr) begin
					wr_cond = 1'b1;
					wdata = rdata_q & ~(WordW'(1) << off_bit);
					r_gr = 1'b1;
				end
			end
			REQ_QUERY: r_gr = inr && rdata_q[off_bit];
			default: fin = 1'b1;
		endcase
	end

	always_comb begin
		st.clr_last = (clr_cnt_q == WAW'(WORD_COUNT - 1));
		st.finish = fin;
		st.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			mem[addr] <= '0;
		end else if (cmd.eval_go && wr_cond) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			type_q <= req_type_t'(in_type);
			id_q <= in_id;
		end
		if (cmd.eval_go && fin) begin
			out_data_q <= {{(OutDataW - IdW - 2){1'b0}}, r_inr, r_gr, r_id};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			cursor_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_cnt_q <= clr_cnt_q + WAW'(1);
			if (cmd.eval_go && cur_upd) cursor_q <= cur_nxt;
			if (cmd.eval_go && fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

/* sv/resource_id_allocator_unit.sv */
// Next-fit id allocator over the range [id_base, id_base + ID_COUNT). One allocated bit
// per id lives in a bitmap memory of 32-bit words, and a cursor that only moves forward
// serves allocate requests; once it reaches the end of the range every later allocate
// reports exhaustion (result_id 0, granted 0), even after frees. Reserve, free and query
// work on a named id. Reserve, free and query each take one read of the bitmap memory
// and one evaluation step before the next request can be accepted; an allocate repeats
// the read and evaluation for each further 32-id word the cursor has to step over
// before it finds a free id or runs off the end. The result is written to an output
// register at the end of the evaluation step and is offered on the next cycle. While it
// waits there the next request is still accepted and read, but the evaluation step that
// settles that request stalls until the earlier result has been taken. After reset the
// bitmap, ceil(ID_COUNT/32) words (32 with the default size), is cleared one word per
// cycle; no request is accepted until then, while id_base may be written at any time
// the block is idle.
module resource_id_allocator_unit import rida_pkg::*; #(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Request stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // [28:0] req_id, [31:29] zero
	input  logic [InUserW-1:0]  s_tuser,  // [1:0] req_type
	// Result stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // [28:0] result_id, [29] granted, [30] in_range, [31] zero
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	logic [IdW-1:0] id_base_q;
	rida_cmd_t      cmd;
	rida_stat_t     st;

	// The only register is id_base at byte address 0; the upper address bit selects
	// nothing, so writes there are dropped and reads return zero.
	assign pready = 1'b1;
	assign prdata = (paddr[ApbAddrW-1] == REG_ID_BASE[ApbAddrW-1]) ?
		{{(ApbDataW - IdW){1'b0}}, id_base_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[ApbAddrW-1] == REG_ID_BASE[ApbAddrW-1]) begin
			id_base_q <= pwdata[IdW-1:0];
		end
	end

	// The controller sequences the clearing pass, then for each request one memory read
	// and one evaluation step, repeating the pair while an allocate scans ahead.
	rida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the bitmap memory, the cursor, the captured request and the
	// output register.
	rida_dp #(
		.ID_COUNT (ID_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.id_base   (id_base_q),
		.in_type   (s_tuser),
		.in_id     (s_tdata[IdW-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef NO_ASSERTIONS
	// One request at a time: acceptance closes the input until the request has settled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in progress");

	// An accepted request always reads its bitmap word in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> cmd.rd_en)
		else $error("accepted request did not read the bitmap");

	// A settled request always shows up at the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval_go && st.finish) |=> m_tvalid)
		else $error("settled request produced no result");

	// The clearing pass never overlaps request traffic.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> (!s_tready && !cmd.rd_en && !cmd.eval_go))
		else $error("request activity during the clearing pass");
`endif

endmodule

/* tb/sv/resource_id_allocator_unit_tb.sv */
`timescale 1ns / 100ps

module resource_id_allocator_unit_tb;
	import rida_pkg::*;

	// Size of the managed range in this build, and the bases used at the two ends.
	localparam int ID_SLOTS = ID_COUNT_DEF;
	localparam logic [IdW-1:0] TOP_FIT_BASE = IdW'((64'd1 << IdW) - ID_SLOTS);
	localparam logic [IdW-1:0] MAX_BASE = '1;
	// Byte address of a register index that the block does not implement.
	localparam logic [ApbAddrW-1:0] SPARE_REG_ADDR = 3'd4;
	// The receiver refuses results for this many cycles once during the run.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any accepted request or result before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEMS_PER_SEGMENT = 100;

	// Predicts the result of every accepted request from its own copy of the bitmap,
	// cursor and base, and checks the results of the block in order against it.
	class id_grant_scoreboard;
		typedef struct packed {
			logic [IdW-1:0] result_id;
			logic           granted;
			logic           in_range;
		} grant_t;

		bit             taken[ID_SLOTS];
		int unsigned    cursor;
		logic [IdW-1:0] base;
		grant_t         pending_grants[$];
		grant_t         last_grant;
		int             mismatches;

		function new();
			cursor = 0;
			base = '0;
			mismatches = 0;
			foreach (taken[i]) taken[i] = 1'b0;
		endfunction

		function void set_base(logic [IdW-1:0] value);
			base = value;
		endfunction

		function void predict_grant(req_type_t kind, logic [IdW-1:0] id);
			grant_t      g;
			int unsigned offset;
			logic        hit;
			// The range test runs on the full 29-bit values, without wrap.
			offset = 32'(id) - 32'(base);
			hit = (id >= base) && (offset < ID_SLOTS);
			if (!hit) offset = 0;
			g.result_id = id;
			g.granted = 1'b0;
			g.in_range = hit;
			case (kind)
				REQ_ALLOC: begin
					// The cursor only moves forward; past the end every allocate fails.
					g.result_id = '0;
					g.in_range = 1'b0;
					while (cursor < ID_SLOTS && !g.granted) begin
						offset = cursor;
						cursor++;
						if (!taken[offset]) begin
							taken[offset] = 1'b1;
							g.result_id = base + offset[IdW-1:0];
							g.granted = 1'b1;
							g.in_range = 1'b1;
						end
					end
				end
				REQ_RESERVE: begin
					if (hit && !taken[offset]) begin
						taken[offset] = 1'b1;
						g.granted = 1'b1;
					end
				end
				REQ_FREE: begin
					if (hit) begin
						taken[offset] = 1'b0;
						g.granted = 1'b1;
					end
				end
				default: begin
					g.granted = hit && taken[offset];
				end
			endcase
			pending_grants.push_back(g);
			last_grant = g;
		endfunction

		function void check_grant(logic [OutDataW-1:0] data);
			grant_t want;
			grant_t got;
			got.result_id = data[IdW-1:0];
			got.granted = data[IdW];
			got.in_range = data[IdW+1];
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tdata %h with no request outstanding", data);
				return;
			end
			want = pending_grants.pop_front();
			if (got.result_id !== want.result_id || got.granted !== want.granted ||
					got.in_range !== want.in_range) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected id %h granted %b in_range %b, got id %h granted %b in_range %b",
						want.result_id, want.granted, want.in_range,
						got.result_id, got.granted, got.in_range);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;   // [28:0] req_id, [31:29] zero
	logic [InUserW-1:0]  s_tuser;   // [1:0] req_type
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;   // [28:0] result_id, [29] granted, [30] in_range, [31] zero
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	id_grant_scoreboard sb;
	int                 items_sent = 0;
	int                 stalled_cycles = 0;
	bit                 idling_on = 1'b1;
	bit                 hold_results = 1'b0;

	resource_id_allocator_unit #(
		.ID_COUNT(ID_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one request and returns at the edge where it is accepted. The valid line
	// stays high on return so that back-to-back requests need no lowering in between.
	task automatic send_request(req_type_t kind, logic [IdW-1:0] id);
		if (idling_on && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= InDataW'(id);
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		sb.predict_grant(kind, id);
		items_sent++;
	endtask

	// Register write: a setup cycle, then an access cycle that completes with pready.
	task automatic write_reg(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_ID_BASE) sb.set_base(data[IdW-1:0]);
	endtask

	// The sender stops and waits for every outstanding result, then waits on for the
	// output register, so that the block is idle before the configuration changes.
	task automatic settle_for_config();
		s_tvalid <= 1'b0;
		while (sb.pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly ids inside the current range, some just at its borders, some anywhere.
	function automatic logic [IdW-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 2) return IdW'($urandom);
		if (r == 2) begin
			case ($urandom_range(3))
				0: return sb.base - 1'b1;
				1: return sb.base + IdW'(ID_SLOTS - 1);
				2: return sb.base + IdW'(ID_SLOTS);
				default: return sb.base;
			endcase
		end
		return sb.base + IdW'($urandom_range(ID_SLOTS - 1));
	endfunction

	// Claims a run of ids right at the cursor, so that the next allocate has to scan
	// across them, often over whole bitmap words.
	task automatic reserve_run_then_alloc();
		int unsigned run_len;
		int unsigned start;
		run_len = $urandom_range(1, 70);
		start = sb.cursor;
		for (int unsigned i = 0; i < run_len; i++) begin
			if (start + i < ID_SLOTS)
				send_request(REQ_RESERVE, sb.base + IdW'(start + i));
		end
		send_request(REQ_ALLOC, '0);
	endtask

	task automatic run_random_sequence();
		int unsigned    r;
		logic [IdW-1:0] got_id;
		r = $urandom_range(19);
		if (r < 9) begin
			send_request(req_type_t'($urandom_range(3)), pick_id());
		end else if (r < 14) begin
			// Life of one id: allocate it, look at it, free it, look again, maybe take it back.
			send_request(REQ_ALLOC, IdW'($urandom));
			if (sb.last_grant.granted) begin
				got_id = sb.last_grant.result_id;
				send_request(REQ_QUERY, got_id);
				send_request(REQ_FREE, got_id);
				send_request(REQ_QUERY, got_id);
				if ($urandom_range(1)) send_request(REQ_RESERVE, got_id);
			end else begin
				send_request(REQ_QUERY, pick_id());
			end
		end else if (r < 17) begin
			reserve_run_then_alloc();
		end else begin
			send_request(req_type_t'($urandom_range(3)), IdW'($urandom));
		end
	endtask

	// Result side: checks every accepted result, stalls at random, and once refuses
	// results for a long stretch while the sender keeps offering requests.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_grant(m_tdata);
			if (hold_results) begin
				hold_results = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= !(idling_on && $urandom_range(99) < 8);
			end
		end
	end

	// Watchdog: a run that stops moving for too long has hung.
	initial begin
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int             stop_at;
		logic [IdW-1:0] new_base;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, base zero: the first allocate yields id 0 with granted set,
		// which must be told apart from exhaustion.
		send_request(REQ_ALLOC, '1);
		send_request(REQ_QUERY, '0);
		send_request(REQ_RESERVE, '0);
		send_request(REQ_RESERVE, 29'd5);
		send_request(REQ_RESERVE, 29'd5);
		send_request(REQ_QUERY, 29'd5);
		send_request(REQ_FREE, 29'd5);
		send_request(REQ_QUERY, 29'd5);
		// Requests just past the end of the range and at the top of the id space.
		send_request(REQ_FREE, IdW'(ID_SLOTS));
		send_request(REQ_RESERVE, IdW'(ID_SLOTS));
		send_request(REQ_QUERY, '1);
		send_request(REQ_RESERVE, IdW'(ID_SLOTS - 1));
		send_request(REQ_QUERY, IdW'(ID_SLOTS - 1));
		send_request(REQ_ALLOC, '0);
		// Allocate steps over ids that were reserved ahead of the cursor.
		send_request(REQ_RESERVE, 29'd2);
		send_request(REQ_RESERVE, 29'd3);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_FREE, 29'h0AAA_AAAA);
		send_request(REQ_QUERY, 29'h1555_5555);

		// Largest base: allocated ids run past 29 bits and come back masked, while the
		// bitmap and cursor keep their offsets across the base change.
		settle_for_config();
		write_reg(REG_ID_BASE, ApbDataW'(MAX_BASE));
		send_request(REQ_ALLOC, '0);
		send_request(REQ_QUERY, MAX_BASE);
		send_request(REQ_RESERVE, '0);
		send_request(REQ_FREE, MAX_BASE);
		// A write to an unimplemented register must leave the base alone.
		settle_for_config();
		write_reg(SPARE_REG_ADDR, ApbDataW'(IdW'($urandom)));
		send_request(REQ_QUERY, MAX_BASE);

		// Random part in segments with a fresh base each. The second segment holds the
		// receiver off for a long stretch; the third runs without any idling.
		for (int seg = 0; seg < 5; seg++) begin
			settle_for_config();
			case (seg)
				0: new_base = TOP_FIT_BASE;
				2: new_base = '0;
				3: new_base = IdW'($urandom_range(4095));
				default: new_base = IdW'($urandom);
			endcase
			write_reg(REG_ID_BASE, ApbDataW'(new_base));
			idling_on = (seg != 2);
			if (seg == 1) hold_results = 1'b1;
			stop_at = items_sent + ITEMS_PER_SEGMENT;
			while (items_sent < stop_at) run_random_sequence();
		end
		idling_on = 1'b1;

		// Drive the cursor to the end of the range, then show that allocate stays
		// exhausted even after ids have been freed.
		while (sb.cursor < ID_SLOTS) begin
			if ($urandom_range(99) < 15)
				reserve_run_then_alloc();
			else
				send_request(REQ_ALLOC, IdW'($urandom));
		end
		new_base = sb.base + IdW'($urandom_range(ID_SLOTS - 1));
		send_request(REQ_FREE, new_base);
		send_request(REQ_FREE, sb.base);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_QUERY, new_base);
		send_request(REQ_ALLOC, '1);
		send_request(REQ_RESERVE, new_base);
		send_request(REQ_QUERY, new_base);

		settle_for_config();
		write_reg(REG_ID_BASE, '0);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_QUERY, '0);

		settle_for_config();
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
